@@ hw/rtl/pid_pkg.sv @@
// ----------------------------------------------------------------------------
// pid_pkg
// Shared codes, widths and control bundle for the pair index decoder.
// ----------------------------------------------------------------------------
package pid_pkg;

    localparam int CNT_BITS  = 16;  // member counts
    localparam int SRCH_BITS = 17;  // first member in triangle modes (<= 65536)
    localparam int SPAN_BITS = 18;  // 2R + 1
    localparam int REG_BITS  = 2;   // register index width
    localparam int MODE_BITS = 3;

    // mapping modes
    localparam logic [MODE_BITS-1:0] MODE_ZIP        = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_PRODUCT    = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_DIRECTED   = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_UPPER      = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_UPPER_DIAG = 3'd4;

    // register indexes
    localparam logic [REG_BITS-1:0] REG_MAP_MODE    = 2'd0;
    localparam logic [REG_BITS-1:0] REG_LEFT_COUNT  = 2'd1;
    localparam logic [REG_BITS-1:0] REG_RIGHT_COUNT = 2'd2;

    // control decoded from the configuration registers
    typedef struct packed {
        logic                  is_prod;   // product mode
        logic                  is_dir;    // directed mode
        logic                  is_tri;    // either triangle mode
        logic                  diag;      // triangle includes the diagonal
        logic                  div_zero;  // division has no valid divisor
        logic [CNT_BITS-1:0]   divisor;
        logic [SRCH_BITS-1:0]  upper;     // largest first member searched
        logic [SPAN_BITS-1:0]  twice;     // 2R + 1 or 2R - 1
    } t_ctl;

endpackage

@@ hw/rtl/pid_stage.sv @@
// ----------------------------------------------------------------------------
// pid_stage
// One pipeline step: one restoring-division quotient bit and, for the low
// bit positions, one bit of the triangle search.
// ----------------------------------------------------------------------------
module pid_stage
    import pid_pkg::*;
#(
    parameter int RW  = 32,   // row / quotient width
    parameter int POS = 0     // bit worked on in this step
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_ctl                 i_ctl,
    input  logic                 i_vld,
    input  logic [RW-1:0]        i_row,
    input  logic [RW-1:0]        i_quo,
    input  logic [CNT_BITS-1:0]  i_rem,
    input  logic [SRCH_BITS-1:0] i_srch,
    input  logic [RW-1:0]        i_pfx,
    output logic                 o_vld,
    output logic [RW-1:0]        o_row,
    output logic [RW-1:0]        o_quo,
    output logic [CNT_BITS-1:0]  o_rem,
    output logic [SRCH_BITS-1:0] o_srch,
    output logic [RW-1:0]        o_pfx
);

    localparam int PW = SRCH_BITS + SPAN_BITS;

    logic                 r_vld;
    logic [RW-1:0]        r_row, r_quo, r_pfx;
    logic [CNT_BITS-1:0]  r_rem;
    logic [SRCH_BITS-1:0] r_srch;

    logic [RW-1:0]        n_quo, n_pfx;
    logic [CNT_BITS-1:0]  n_rem;
    logic [SRCH_BITS-1:0] n_srch;
    logic [CNT_BITS:0]    sh;
    logic                 ge;

    // restoring division step
    always_comb begin
        sh    = {i_rem, i_row[POS]};
        ge    = sh >= {1'b0, i_ctl.divisor};
        n_rem = ge ? CNT_BITS'(sh - {1'b0, i_ctl.divisor}) : CNT_BITS'(sh);
        n_quo = i_quo;
        n_quo[POS] = ge;
    end

    // triangle search step: keep the bit if the candidate stays within upper and its prefix still fits under row
    generate
        if (POS < SRCH_BITS) begin : g_srch
            logic [SRCH_BITS-1:0] cand;
            logic [SPAN_BITS-1:0] span;
            logic [PW-1:0]        prod;
            logic                 take;
            always_comb begin
                cand = i_srch | (SRCH_BITS'(1) << POS);
                span = i_ctl.twice - {1'b0, cand};
                prod = PW'(cand) * PW'(span);
                take = (cand <= i_ctl.upper) && ((prod >> 1) <= PW'(i_row));
                n_srch = take ? cand : i_srch;
                n_pfx  = take ? RW'(prod >> 1) : i_pfx;
            end
        end else begin : g_pass
            assign n_srch = i_srch;
            assign n_pfx  = i_pfx;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row  <= i_row;
            r_quo  <= n_quo;
            r_rem  <= n_rem;
            r_srch <= n_srch;
            r_pfx  <= n_pfx;
        end
    end

    assign o_vld  = r_vld;
    assign o_row  = r_row;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_srch = r_srch;
    assign o_pfx  = r_pfx;

endmodule

@@ hw/rtl/pid_out.sv @@
// ----------------------------------------------------------------------------
// pid_out
// Final stage: picks the pair for the mode and holds the result word.
// ----------------------------------------------------------------------------
module pid_out
    import pid_pkg::*;
#(
    parameter int RW = 32,
    parameter int IB = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_ctl                 i_ctl,
    input  logic                 i_vld,
    input  logic [RW-1:0]        i_row,
    input  logic [RW-1:0]        i_quo,
    input  logic [CNT_BITS-1:0]  i_rem,
    input  logic [SRCH_BITS-1:0] i_srch,
    input  logic [RW-1:0]        i_pfx,
    output logic                 o_vld,
    output logic [31:0]          o_first,
    output logic [31:0]          o_second,
    output logic                 o_bad
);

    logic              r_vld, r_bad;
    logic [IB-1:0]     r_first, r_second;
    logic [IB-1:0]     n_first, n_second;
    logic              n_bad;
    logic [RW-1:0]     tri_second;
    logic [RW-1:0]     dir_second;

    // zip is the fallback, so the mode tests may all be false
    always_comb begin
        tri_second = RW'(i_srch) + RW'(!i_ctl.diag) + i_row - i_pfx;
        dir_second = RW'(i_rem) + RW'(RW'(i_rem) >= i_quo);
        n_bad      = 1'b0;
        n_first    = IB'(i_row);
        n_second   = IB'(i_row);
        if (i_ctl.is_prod || i_ctl.is_dir) begin
            if (i_ctl.div_zero) begin
                n_bad    = 1'b1;
                n_first  = '0;
                n_second = '0;
            end else begin
                n_first  = IB'(i_quo);
                n_second = i_ctl.is_dir ? IB'(dir_second) : IB'(i_rem);
            end
        end else if (i_ctl.is_tri) begin
            n_first  = IB'(i_srch);
            n_second = IB'(tri_second);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_bad    <= n_bad;
        end
    end

    assign o_vld    = r_vld;
    assign o_first  = 32'(r_first);
    assign o_second = 32'(r_second);
    assign o_bad    = r_bad;

endmodule

@@ hw/rtl/pair_index_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// pair_index_decoder_unit
// Turns a flat pair row number into its two member indices (zip, product,
// directed, upper triangle strict or with diagonal).
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------------------
//  row in   | in        | i_valid / o_stall     | i_row_index
//  pair out | out       | o_valid / i_stall     | o_first_member, o_second_member,
//           |           |                       | o_bad_divisor
//  config   | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One word enters per cycle unless o_stall is high; each word passes the
//  one-quotient-bit-per-stage divider stages and then the output stage.
//  The whole pipeline holds while a result waits under i_stall; bubbles stay.
//  Synchronous active-low reset clears valid bits and loads register resets.
//  Configuration writes are always taken (o_cfg_ready is tied high).
module pair_index_decoder_unit
    import pid_pkg::*;
#(
    parameter int INDEX_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [REG_BITS-1:0] i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [31:0]         i_row_index,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [31:0]         o_first_member,
    output logic [31:0]         o_second_member,
    output logic                o_bad_divisor
);

    localparam int NSTG = (INDEX_BITS > SRCH_BITS) ? INDEX_BITS : SRCH_BITS;

    logic [MODE_BITS-1:0] r_mode;
    logic [CNT_BITS-1:0]  r_left, r_right;
    t_ctl                 ctl;
    logic                 en;
    logic [CNT_BITS-1:0]  top;
    logic [SRCH_BITS-1:0] peak;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ZIP;
            r_left  <= CNT_BITS'(1);
            r_right <= CNT_BITS'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MAP_MODE:    r_mode  <= MODE_BITS'(i_cfg_data);
                REG_LEFT_COUNT:  r_left  <= i_cfg_data;
                REG_RIGHT_COUNT: r_right <= i_cfg_data;
                default:         ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // decode the mode into the control bundle
    always_comb begin
        ctl.is_prod  = r_mode == MODE_PRODUCT;
        ctl.is_dir   = r_mode == MODE_DIRECTED;
        ctl.diag     = r_mode == MODE_UPPER_DIAG;
        ctl.is_tri   = (r_mode == MODE_UPPER) || ctl.diag;
        ctl.div_zero = ctl.is_dir ? (r_right <= CNT_BITS'(1)) : (r_right == '0);
        ctl.divisor  = ctl.is_dir ? r_right - CNT_BITS'(1) : r_right;
        top          = (r_left == '0) ? '0 : r_left - CNT_BITS'(1);
        peak         = ctl.diag ? SRCH_BITS'(r_right) + SRCH_BITS'(1) : SRCH_BITS'(r_right);
        ctl.upper    = (SRCH_BITS'(top) > peak) ? peak : SRCH_BITS'(top);
        ctl.twice    = ctl.diag ? {1'b0, r_right, 1'b1}
                                : {1'b0, r_right, 1'b0} - SPAN_BITS'(1);
    end

    // pipeline advances unless a result is held by the consumer
    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    logic                 s_vld  [NSTG+1];
    logic [NSTG-1:0]      s_row  [NSTG+1];
    logic [NSTG-1:0]      s_quo  [NSTG+1];
    logic [CNT_BITS-1:0]  s_rem  [NSTG+1];
    logic [SRCH_BITS-1:0] s_srch [NSTG+1];
    logic [NSTG-1:0]      s_pfx  [NSTG+1];

    assign s_vld[0]  = i_valid;
    assign s_row[0]  = NSTG'(i_row_index[INDEX_BITS-1:0]);
    assign s_quo[0]  = '0;
    assign s_rem[0]  = '0;
    assign s_srch[0] = '0;
    assign s_pfx[0]  = '0;

    generate
        for (genvar s = 0; s < NSTG; s++) begin : g_stage
            pid_stage #(.RW(NSTG), .POS(NSTG - 1 - s)) u_stage (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (en),
                .i_ctl  (ctl),
                .i_vld  (s_vld[s]),
                .i_row  (s_row[s]),
                .i_quo  (s_quo[s]),
                .i_rem  (s_rem[s]),
                .i_srch (s_srch[s]),
                .i_pfx  (s_pfx[s]),
                .o_vld  (s_vld[s+1]),
                .o_row  (s_row[s+1]),
                .o_quo  (s_quo[s+1]),
                .o_rem  (s_rem[s+1]),
                .o_srch (s_srch[s+1]),
                .o_pfx  (s_pfx[s+1])
            );
        end
    endgenerate

    pid_out #(.RW(NSTG), .IB(INDEX_BITS)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (ctl),
        .i_vld   (s_vld[NSTG]),
        .i_row   (s_row[NSTG]),
        .i_quo   (s_quo[NSTG]),
        .i_rem   (s_rem[NSTG]),
        .i_srch  (s_srch[NSTG]),
        .i_pfx   (s_pfx[NSTG]),
        .o_vld   (o_valid),
        .o_first (o_first_member),
        .o_second(o_second_member),
        .o_bad   (o_bad_divisor)
    );

    // a zero-divisor flag only comes out of the dividing modes
    a_bad_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_divisor |-> (r_mode == MODE_PRODUCT) || (r_mode == MODE_DIRECTED))
        else $error("bad divisor outside dividing mode");

    // a flagged word carries a zero pair
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_divisor |-> (o_first_member == '0) && (o_second_member == '0))
        else $error("flagged word has non-zero pair");

    // product remainder stays below the right count
    a_prod_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_bad_divisor && (r_mode == MODE_PRODUCT)
        |-> o_second_member < 32'(r_right))
        else $error("product remainder out of range");

    // a held result does not change while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_first_member) && $stable(o_second_member))
        else $error("held result changed");

endmodule
